### hdl/boq_pkg.sv
// ----------------------------------------------------------------------------
// boq_pkg
// shared types and constants of the bounded ordered queue
// ----------------------------------------------------------------------------
package boq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int INDEX_W       = 6;
   localparam int MODE_W        = 3;
   localparam int COUNT_W       = 7;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 40;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GET    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

   localparam logic [VALUE_W-1:0] FAIL_DATA = '1;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH,
      OP_INSERT,
      OP_POP,
      OP_ERASE,
      OP_GET,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_WRITE,
      ST_TAIL,
      ST_GETWAIT,
      ST_DONE
   } state_type;

endpackage

### hdl/boq_ram.sv
// ----------------------------------------------------------------------------
// boq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module boq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/boq_front.sv
// ----------------------------------------------------------------------------
// boq_front
// accepts request items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module boq_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [boq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                       cmd_valid,
   input  logic                       cmd_take,
   output boq_pkg::cmd_type           cmd
);

   boq_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   boq_pkg::cmd_type new_cmd;
   logic             push_en;
   logic             pop_en;

   logic [boq_pkg::MODE_W-1:0]  mode;
   logic [boq_pkg::VALUE_W-1:0] value;

   assign mode  = req_tdata[2:0];
   assign value = req_tdata[34:3];

   // classify: negative push or insert and unused modes become no-ops
   always_comb begin
      new_cmd.value = value;
      new_cmd.index = req_tdata[40:35];
      unique case (mode)
         boq_pkg::MODE_PUSH:   new_cmd.op = value[31] ? boq_pkg::OP_NOP : boq_pkg::OP_PUSH;
         boq_pkg::MODE_INSERT: new_cmd.op = value[31] ? boq_pkg::OP_NOP : boq_pkg::OP_INSERT;
         boq_pkg::MODE_POP:    new_cmd.op = boq_pkg::OP_POP;
         boq_pkg::MODE_ERASE:  new_cmd.op = boq_pkg::OP_ERASE;
         boq_pkg::MODE_GET:    new_cmd.op = boq_pkg::OP_GET;
         boq_pkg::MODE_CLEAR:  new_cmd.op = boq_pkg::OP_CLEAR;
         default:              new_cmd.op = boq_pkg::OP_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push_en    = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign pop_en     = cmd_valid && cmd_take;
   assign cmd        = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push_en ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop_en ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + {1'b0, push_en} - {1'b0, pop_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### hdl/boq_back.sv
// ----------------------------------------------------------------------------
// boq_back
// carries out queued commands on the list ram and registers the result
// ----------------------------------------------------------------------------
module boq_back #(
   parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_take,
   input  boq_pkg::cmd_type           cmd,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [boq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > boq_pkg::INDEX_W) ? CW : boq_pkg::INDEX_W;

   boq_pkg::state_type state_ff, state_in;
   boq_pkg::cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [31:0]        carry_ff, carry_in;
   logic               placed_ff, placed_in;
   logic               ok_ff, ok_in;
   logic [31:0]        data_ff, data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic [boq_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic          full;
   logic          empty;
   logic          last;
   logic          slot_free;
   logic          keep;
   logic [CW-1:0] j_next;

   assign full      = (fill_ff == CW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign last      = (CW'(i_ff + 1'b1) == fill_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign keep      = (rd_data != cmd_ff.value);
   assign j_next    = keep ? CW'(j_ff + 1'b1) : j_ff;

   boq_ram #(
      .WIDTH (boq_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         boq_pkg::ST_IDLE: begin
            if (cmd_valid) state_in = boq_pkg::ST_EXEC;
         end
         boq_pkg::ST_EXEC: begin
            unique case (cmd_ff.op)
               boq_pkg::OP_INSERT: state_in = (full || empty) ? boq_pkg::ST_DONE
                                                              : boq_pkg::ST_READ;
               boq_pkg::OP_POP,
               boq_pkg::OP_ERASE:  state_in = empty ? boq_pkg::ST_DONE : boq_pkg::ST_READ;
               boq_pkg::OP_GET:    state_in = (CMPW'(cmd_ff.index) < CMPW'(fill_ff))
                                              ? boq_pkg::ST_GETWAIT : boq_pkg::ST_DONE;
               default:            state_in = boq_pkg::ST_DONE;
            endcase
         end
         boq_pkg::ST_READ:    state_in = boq_pkg::ST_WRITE;
         boq_pkg::ST_WRITE: begin
            if (!last) state_in = boq_pkg::ST_READ;
            else if (cmd_ff.op == boq_pkg::OP_INSERT) state_in = boq_pkg::ST_TAIL;
            else state_in = boq_pkg::ST_DONE;
         end
         boq_pkg::ST_TAIL:    state_in = boq_pkg::ST_DONE;
         boq_pkg::ST_GETWAIT: state_in = boq_pkg::ST_DONE;
         boq_pkg::ST_DONE: begin
            if (slot_free) state_in = boq_pkg::ST_IDLE;
         end
         default: state_in = boq_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      cmd_take     = 1'b0;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      carry_in     = carry_ff;
      placed_in    = placed_ff;
      ok_in        = ok_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(i_ff);
      wr_data      = cmd_ff.value;
      rd_addr      = AW'(i_ff);
      unique case (state_ff)
         boq_pkg::ST_IDLE: begin
            cmd_take = cmd_valid;
            cmd_in   = cmd;
         end
         boq_pkg::ST_EXEC: begin
            ok_in     = 1'b0;
            data_in   = '0;
            i_in      = '0;
            j_in      = '0;
            placed_in = 1'b0;
            unique case (cmd_ff.op)
               boq_pkg::OP_PUSH: begin
                  if (!full) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(fill_ff);
                     fill_in = CW'(fill_ff + 1'b1);
                     ok_in   = 1'b1;
                  end
               end
               boq_pkg::OP_INSERT: begin
                  // an empty list takes the value at the head at once
                  if (!full && empty) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     fill_in = CW'(fill_ff + 1'b1);
                     ok_in   = 1'b1;
                  end
               end
               boq_pkg::OP_POP: begin
                  if (empty) data_in = boq_pkg::FAIL_DATA;
               end
               boq_pkg::OP_GET: begin
                  rd_addr = AW'(cmd_ff.index);
                  if (CMPW'(cmd_ff.index) >= CMPW'(fill_ff)) data_in = boq_pkg::FAIL_DATA;
               end
               boq_pkg::OP_CLEAR: begin
                  fill_in = '0;
                  ok_in   = 1'b1;
               end
               default: begin
               end
            endcase
         end
         boq_pkg::ST_READ: begin
            rd_addr = AW'(i_ff);
         end
         boq_pkg::ST_WRITE: begin
            i_in = CW'(i_ff + 1'b1);
            unique case (cmd_ff.op)
               boq_pkg::OP_INSERT: begin
                  // ripple the displaced entry one place toward the tail
                  if (!placed_ff && ($signed(rd_data) <= $signed(cmd_ff.value))) begin
                     wr_en     = 1'b1;
                     wr_data   = cmd_ff.value;
                     carry_in  = rd_data;
                     placed_in = 1'b1;
                  end else if (placed_ff) begin
                     wr_en    = 1'b1;
                     wr_data  = carry_ff;
                     carry_in = rd_data;
                  end
               end
               boq_pkg::OP_POP: begin
                  if (i_ff == '0) begin
                     data_in = rd_data;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(i_ff - 1'b1);
                     wr_data = rd_data;
                  end
                  if (last) begin
                     fill_in = CW'(fill_ff - 1'b1);
                     ok_in   = 1'b1;
                  end
               end
               boq_pkg::OP_ERASE: begin
                  // compact the survivors toward the head
                  if (keep) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(j_ff);
                     wr_data = rd_data;
                  end
                  j_in = j_next;
                  if (last) begin
                     ok_in   = (j_next != fill_ff);
                     fill_in = j_next;
                  end
               end
               default: begin
               end
            endcase
         end
         boq_pkg::ST_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = AW'(fill_ff);
            wr_data = placed_ff ? carry_ff : cmd_ff.value;
            fill_in = CW'(fill_ff + 1'b1);
            ok_in   = 1'b1;
         end
         boq_pkg::ST_GETWAIT: begin
            data_in = rd_data;
            ok_in   = 1'b1;
         end
         boq_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = data_ff;
               rsp_count_in = boq_pkg::COUNT_W'(fill_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= boq_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      carry_ff     <= carry_in;
      placed_ff    <= placed_in;
      ok_ff        <= ok_in;
      data_ff      <= data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_data_ff, rsp_ok_ff};

endmodule

### hdl/bounded_ordered_queue_core.sv
// ----------------------------------------------------------------------------
// bounded_ordered_queue_core
// ordered list of up to DEPTH signed values with push, insert, pop, erase,
// get and clear requests, one response item per request item
// ----------------------------------------------------------------------------
// every request item yields exactly one response item holding ok, data and
// the entry count after the request. a front end takes items into a two
// item command queue while the back end works, and a response register
// lets the next request start while a finished response waits. the list
// lives in a single ram with one write and one registered read port, so
// work that moves entries walks the list one entry at a time, reading it in
// the read state and writing it back in the write state. push, clear,
// rejected or unused requests and failed pops or gets pass through the
// idle, exec and done states; get adds getwait, and insert into a
// non-empty, non-full list adds tail after its walk. no clearing pass is
// needed after reset.
module bounded_ordered_queue_core #(
   parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[2:0], value[34:3], index[40:35], zero pad
   input  logic [boq_pkg::REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // ok[0], data[32:1], count[39:33]
   output logic [boq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // classified command handed from front end to back end
   logic             cmd_valid;
   logic             cmd_take;
   boq_pkg::cmd_type cmd;

   // front end: accept, classify, queue
   boq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take),
      .cmd        (cmd)
   );

   // back end: list ram walk and response register
   boq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
